@@ sv/mmcv_pkg.sv @@
// Package: shared types, codes and sizes for the MIDI note to CV converter.
package mmcv_pkg;

  localparam int NOTE_SLOTS    = 8;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QUEUE_PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 8;

  localparam logic [7:0] STATUS_MASK     = 8'hF0;
  localparam logic [7:0] STATUS_NOTE_ON  = 8'h90;
  localparam logic [7:0] STATUS_NOTE_OFF = 8'h80;

  localparam logic [CFG_IDX_W-1:0] CFG_OCTAVE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEMITONE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CENT      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRIGGER = 2'd3;

  typedef enum logic [1:0] {
    OP_OTHER    = 2'd0,
    OP_NOTE_ON  = 2'd1,
    OP_NOTE_OFF = 2'd2,
    OP_TICK     = 2'd3
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [6:0] note;
    logic [6:0] vel;
  } q_entry_t;

  typedef struct packed {
    logic     push;
    q_entry_t entry;
  } q_push_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_head_t;

  typedef struct packed {
    logic signed [3:0] octave_offset;
    logic signed [4:0] semitone_offset;
    logic signed [7:0] cent_offset;
    logic              retrigger_enable;
  } cfg_t;

endpackage

@@ sv/mmcv_if.sv @@
// Interfaces: input event channel and output CV result channel.
interface mmcv_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] status_byte;
  logic [6:0] note_number;
  logic [6:0] note_velocity;

  modport source (output valid, output func, output status_byte, output note_number,
                  output note_velocity, input ready);
  modport sink (input valid, input func, input status_byte, input note_number,
                input note_velocity, output ready);
endinterface

interface mmcv_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pitch_cents;
  logic        [6:0]  velocity_level;
  logic               gate;

  modport source (output valid, output pitch_cents, output velocity_level, output gate,
                  input ready);
  modport sink (input valid, input pitch_cents, input velocity_level, input gate,
                output ready);
endinterface

@@ sv/mmcv_front.sv @@
// Front end: accept input transfers and classify them into queue operations.
module mmcv_front (
  mmcv_in_if.sink          in_i,
  input  logic             full_i,
  output mmcv_pkg::q_push_t push_o
);
  import mmcv_pkg::*;

  logic [7:0] status_hi;

  assign in_i.ready = ~full_i;
  assign status_hi  = in_i.status_byte & STATUS_MASK;

  always_comb begin
    push_o.push       = in_i.valid & ~full_i;
    push_o.entry.note = in_i.note_number;
    push_o.entry.vel  = in_i.note_velocity;
    if (in_i.func) begin
      push_o.entry.op = OP_TICK;
    end else if (status_hi == STATUS_NOTE_ON) begin
      push_o.entry.op = OP_NOTE_ON;
    end else if (status_hi == STATUS_NOTE_OFF) begin
      push_o.entry.op = OP_NOTE_OFF;
    end else begin
      push_o.entry.op = OP_OTHER;
    end
  end

endmodule

@@ sv/mmcv_queue.sv @@
// Queue: short FIFO of classified operations between front and back.
module mmcv_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mmcv_pkg::q_push_t push_i,
  input  logic              pop_i,
  output logic              full_o,
  output mmcv_pkg::q_head_t head_o
);
  import mmcv_pkg::*;

  q_entry_t               mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QUEUE_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QUEUE_CNT_W-1:0] count_q, count_d;
  logic                   do_push, do_pop;

  assign full_o       = (count_q == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign head_o.valid = (count_q != '0);
  assign head_o.entry = mem_q[rd_ptr_q];
  assign do_push      = push_i.push & ~full_o;
  assign do_pop       = pop_i & head_o.valid;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.entry;
    end
  end

endmodule

@@ sv/mmcv_back.sv @@
// Back end: held-note list, current note state and registered CV output.
module mmcv_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mmcv_pkg::cfg_t    cfg_i,
  input  mmcv_pkg::q_head_t head_i,
  output logic              pop_o,
  mmcv_out_if.source        out_o
);
  import mmcv_pkg::*;

  localparam logic signed [17:0] CENTS_PER_OCTAVE   = 18'sd1200;
  localparam logic signed [17:0] CENTS_PER_SEMITONE = 18'sd100;

  logic [NOTE_SLOTS-1:0] slot_valid_q, slot_valid_d;
  logic [6:0]            slot_note_q [NOTE_SLOTS];
  logic [6:0]            slot_note_d [NOTE_SLOTS];
  logic [6:0]            cur_note_q, cur_note_d;
  logic [6:0]            cur_vel_q, cur_vel_d;
  logic                  gate_q, gate_d;
  logic                  pend_q, pend_d;
  logic                  out_valid_q, out_valid_d;
  logic signed [15:0]    pitch_q, pitch_d;
  logic [6:0]            vel_out_q, vel_out_d;
  logic                  gate_out_q, gate_out_d;
  logic                  found;
  logic                  is_tick;
  logic signed [17:0]    pitch_full;

  assign is_tick = (head_i.entry.op == OP_TICK);
  assign pop_o   = head_i.valid & (~is_tick | ~out_valid_q | out_o.ready);

  assign pitch_full = CENTS_PER_OCTAVE * 18'(cfg_i.octave_offset)
                    + CENTS_PER_SEMITONE * (18'(cfg_i.semitone_offset)
                                            + $signed({11'b0, cur_note_q}))
                    + 18'(cfg_i.cent_offset);

  always_comb begin
    slot_valid_d = slot_valid_q;
    slot_note_d  = slot_note_q;
    cur_note_d   = cur_note_q;
    cur_vel_d    = cur_vel_q;
    gate_d       = gate_q;
    pend_d       = pend_q;
    pitch_d      = pitch_q;
    vel_out_d    = vel_out_q;
    gate_out_d   = gate_out_q;
    out_valid_d  = out_valid_q & ~out_o.ready;
    found        = 1'b0;

    if (pop_o) begin
      unique case (head_i.entry.op)
        OP_NOTE_ON: begin
          for (int i = 0; i < NOTE_SLOTS; i++) begin
            if (!found && !slot_valid_q[i]) begin
              slot_valid_d[i] = 1'b1;
              slot_note_d[i]  = head_i.entry.note;
              found           = 1'b1;
            end
          end
          cur_note_d = head_i.entry.note;
          cur_vel_d  = head_i.entry.vel;
          pend_d     = 1'b1;
        end
        OP_NOTE_OFF: begin
          for (int i = 0; i < NOTE_SLOTS; i++) begin
            if (slot_valid_q[i] && slot_note_q[i] == head_i.entry.note) begin
              slot_valid_d[i] = 1'b0;
            end
          end
          // highest remaining slot wins: later hits overwrite earlier ones
          for (int i = 0; i < NOTE_SLOTS; i++) begin
            if (slot_valid_d[i]) begin
              cur_note_d = slot_note_q[i];
            end
          end
        end
        OP_OTHER: begin
        end
        OP_TICK: begin
          out_valid_d = 1'b1;
          pitch_d     = $signed(pitch_full[15:0]);
          vel_out_d   = cur_vel_q;
          gate_out_d  = gate_q;
          if (pend_q && cfg_i.retrigger_enable) begin
            pend_d     = 1'b0;
            gate_out_d = 1'b0;
          end
        end
        default: begin
        end
      endcase

      if (!is_tick) begin
        gate_d = |slot_valid_d;
        if (!(|slot_valid_d)) begin
          cur_vel_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q <= '0;
      cur_note_q   <= '0;
      cur_vel_q    <= '0;
      gate_q       <= 1'b0;
      pend_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      slot_valid_q <= slot_valid_d;
      cur_note_q   <= cur_note_d;
      cur_vel_q    <= cur_vel_d;
      gate_q       <= gate_d;
      pend_q       <= pend_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_note_q <= slot_note_d;
    pitch_q     <= pitch_d;
    vel_out_q   <= vel_out_d;
    gate_out_q  <= gate_out_d;
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.pitch_cents    = pitch_q;
  assign out_o.velocity_level = vel_out_q;
  assign out_o.gate           = gate_out_q;

endmodule

@@ sv/mono_midi_note_to_cv_core.sv @@
// Top level: monophonic MIDI note to pitch / velocity / gate CV converter.
// Path: a tick accepted at the input is written into the queue, popped by the
//   back end and registered in the output register, which then offers its result.
// Throughput: one item per cycle while results are taken; the back end retires
//   one queued item a cycle unless a tick stalls on the one-deep output register.
//   A tick waits in the queue while the output register holds an untaken result.
// Reset: rst_ni clears the note list, note state, queue and output valid at
//   once; configuration resets to zero offsets and retrigger off.
module mono_midi_note_to_cv_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mmcv_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [mmcv_pkg::CFG_DATA_W-1:0] cfg_data_i,
  mmcv_in_if.sink                        in_i,
  mmcv_out_if.source                     out_o
);
  import mmcv_pkg::*;

  // Configuration registers; the user must write them only while the block is idle, the block does not enforce this.
  cfg_t    cfg_q;
  q_push_t push;
  q_head_t head;
  logic    q_full;
  logic    pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_OCTAVE:    cfg_q.octave_offset    <= $signed(cfg_data_i[3:0]);
        CFG_SEMITONE:  cfg_q.semitone_offset  <= $signed(cfg_data_i[4:0]);
        CFG_CENT:      cfg_q.cent_offset      <= $signed(cfg_data_i);
        CFG_RETRIGGER: cfg_q.retrigger_enable <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // Front: take each input transfer and tag it as note-on, note-off,
  // other MIDI or sample tick.
  mmcv_front u_front (
    .in_i   (in_i),
    .full_i (q_full),
    .push_o (push)
  );

  // Queue: decouple acceptance from execution so a stalled output does
  // not block intake until the queue fills.
  mmcv_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .full_o (q_full),
    .head_o (head)
  );

  // Back: update the held-note list on MIDI events, produce a CV result
  // transfer on each tick; hold a tick while the output register is full.
  mmcv_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .head_i (head),
    .pop_o  (pop),
    .out_o  (out_o)
  );

endmodule

@@ tb/mono_midi_note_to_cv_core_test.sv @@
// Testbench: checks the MIDI note to CV converter against its own note-list and pitch predictor.
module mono_midi_note_to_cv_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mmcv_pkg::*;

  // Item kinds on the input channel.
  localparam logic FUNC_MIDI = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // Receiver hold-off used to fill the block and stall its input.
  localparam int LONG_HOLD  = 60;
  // Cycles to let pass once the last tick result is in; events give no result.
  localparam int SETTLE_CYC = 6;
  // Watchdog, far beyond the slowest correct run.
  localparam longint TIMEOUT_NS = 64'd5_000_000;

  typedef struct {
    logic signed [15:0] pitch;
    logic [6:0]         vel;
    logic               gate;
  } cv_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  mmcv_in_if  in_bus ();
  mmcv_out_if out_bus ();

  mono_midi_note_to_cv_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_bus.sink),
    .out_o      (out_bus.source)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor state: the held-note list, the current note and velocity, the
  // gate and the armed retrigger flag, plus a shadow of the tuning registers.
  // ---------------------------------------------------------------------------
  logic       slot_held [NOTE_SLOTS];
  logic [6:0] slot_note [NOTE_SLOTS];
  logic [6:0] cur_note;
  logic [6:0] cur_vel;
  logic       gate_q;
  logic       retrig_armed;
  cfg_t       tuning;

  cv_result_t pending_cv_q[$];
  int         cv_errors;

  // Idle control for both sides of the block.
  bit tx_idle_on;
  bit rx_idle_on;
  bit rx_hold_req;
  int rx_hold_left;
  int rx_stall_left;

  // Advance the predictor by one accepted item; a tick queues one CV result.
  function automatic void apply_midi_item(logic func, logic [7:0] status,
                                          logic [6:0] note, logic [6:0] vel);
    op_e        kind;
    logic       placed;
    logic       found;
    logic       any_held;
    int         cents;
    cv_result_t res;
    if (func == FUNC_TICK) begin
      kind = OP_TICK;
    end else if ((status & STATUS_MASK) == STATUS_NOTE_ON) begin
      kind = OP_NOTE_ON;
    end else if ((status & STATUS_MASK) == STATUS_NOTE_OFF) begin
      kind = OP_NOTE_OFF;
    end else begin
      kind = OP_OTHER;
    end

    case (kind)
      OP_TICK: begin
        cents = 1200 * $signed(tuning.octave_offset) + 100 * $signed(tuning.semitone_offset)
              + $signed(tuning.cent_offset) + 100 * int'(cur_note);
        res.pitch = cents[15:0];
        res.vel   = cur_vel;
        res.gate  = gate_q;
        // An armed retrigger pulls the gate low for this one tick only.
        if (retrig_armed && tuning.retrigger_enable) begin
          retrig_armed = 1'b0;
          res.gate     = 1'b0;
        end
        pending_cv_q.push_back(res);
        return;
      end
      OP_NOTE_ON: begin
        // Take the lowest free slot; when the list is full the note is
        // not stored but still becomes the current note.
        placed = 1'b0;
        for (int i = 0; i < NOTE_SLOTS; i++) begin
          if (!placed && !slot_held[i]) begin
            slot_held[i] = 1'b1;
            slot_note[i] = note;
            placed       = 1'b1;
          end
        end
        cur_note     = note;
        cur_vel      = vel;
        retrig_armed = 1'b1;
      end
      OP_NOTE_OFF: begin
        // Drop every copy of the note, then fall back to the highest held slot.
        for (int i = 0; i < NOTE_SLOTS; i++) begin
          if (slot_held[i] && slot_note[i] == note) slot_held[i] = 1'b0;
        end
        found = 1'b0;
        for (int i = NOTE_SLOTS - 1; i >= 0; i--) begin
          if (!found && slot_held[i]) begin
            cur_note = slot_note[i];
            found    = 1'b1;
          end
        end
      end
      default: ;
    endcase

    // Every MIDI event, recognized or not, re-evaluates the gate.
    any_held = 1'b0;
    for (int i = 0; i < NOTE_SLOTS; i++) any_held |= slot_held[i];
    if (any_held) begin
      gate_q = 1'b1;
    end else begin
      gate_q  = 1'b0;
      cur_vel = '0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor and checker: register writes and input transfers feed the
  // predictor, output transfers are compared with the oldest expected result.
  // All sampling happens at the rising edge, before the block updates.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    cv_result_t want;
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_OCTAVE:    tuning.octave_offset    = cfg_data_i[3:0];
          CFG_SEMITONE:  tuning.semitone_offset  = cfg_data_i[4:0];
          CFG_CENT:      tuning.cent_offset      = cfg_data_i[7:0];
          CFG_RETRIGGER: tuning.retrigger_enable = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_bus.valid && in_bus.ready) begin
        apply_midi_item(in_bus.func, in_bus.status_byte, in_bus.note_number,
                        in_bus.note_velocity);
      end
      if (out_bus.valid && out_bus.ready) begin
        if (pending_cv_q.size() == 0) begin
          cv_errors++;
          if (cv_errors <= 10) begin
            $display("%0t: unexpected CV result: pitch %0d vel %0d gate %0b", $realtime,
                     out_bus.pitch_cents, out_bus.velocity_level, out_bus.gate);
          end
        end else begin
          want = pending_cv_q.pop_front();
          if (out_bus.pitch_cents !== want.pitch || out_bus.velocity_level !== want.vel ||
              out_bus.gate !== want.gate) begin
            cv_errors++;
            if (cv_errors <= 10) begin
              $display("%0t: CV result differs: expected pitch %0d vel %0d gate %0b, got pitch %0d vel %0d gate %0b",
                       $realtime, want.pitch, want.vel, want.gate,
                       out_bus.pitch_cents, out_bus.velocity_level, out_bus.gate);
            end
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: drives ready at the falling edge. A long hold-off, when asked
  // for, is counted here; otherwise, with idle on, random stall bursts.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else if (rx_hold_req) begin
      rx_hold_req  = 1'b0;
      rx_hold_left = LONG_HOLD - 1;
      out_bus.ready <= 1'b0;
    end else if (rx_hold_left != 0) begin
      rx_hold_left--;
      out_bus.ready <= 1'b0;
    end else if (rx_stall_left != 0) begin
      rx_stall_left--;
      out_bus.ready <= 1'b0;
    end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
      rx_stall_left = $urandom_range(0, 13);
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  // Offer one item and hold it until the transfer. Valid stays high after
  // the transfer so back-to-back items need no extra assignment.
  task automatic send_item(logic func, logic [7:0] status, logic [6:0] note, logic [6:0] vel);
    int gap;
    @(negedge clk_i);
    if (tx_idle_on && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 14);
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_bus.valid         <= 1'b1;
    in_bus.func          <= func;
    in_bus.status_byte   <= status;
    in_bus.note_number   <= note;
    in_bus.note_velocity <= vel;
    do @(posedge clk_i); while (in_bus.ready !== 1'b1);
  endtask

  // A tick carries don't-care data; randomize it so the block must ignore it.
  task automatic send_tick();
    send_item(FUNC_TICK, 8'($urandom), 7'($urandom), 7'($urandom));
  endtask

  // Drop valid and wait until every expected result is in, then let the
  // last MIDI events work their way through.
  task automatic settle();
    @(negedge clk_i);
    in_bus.valid <= 1'b0;
    while (pending_cv_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  // Write one register; bits above the field get random junk.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
    logic [7:0] data;
    data = 8'($urandom);
    case (idx)
      CFG_OCTAVE:    data[3:0] = value[3:0];
      CFG_SEMITONE:  data[4:0] = value[4:0];
      CFG_CENT:      data      = value[7:0];
      CFG_RETRIGGER: data[0]   = value[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // Mostly well-formed note traffic around a small pool of notes so slots
  // match, fill up and free again; ticks in between; some random noise.
  task automatic send_random_item(logic [6:0] pool_base);
    int         pick;
    logic [6:0] note;
    logic [6:0] vel;
    logic [3:0] chan;
    pick = $urandom_range(0, 99);
    chan = 4'($urandom);
    note = ($urandom_range(0, 3) != 0) ? pool_base + 7'($urandom_range(0, 5))
                                       : 7'($urandom_range(0, 127));
    case ($urandom_range(0, 9))
      0:       vel = 7'd0;
      1:       vel = 7'd127;
      default: vel = 7'($urandom);
    endcase
    if (pick < 35) begin
      send_tick();
    end else if (pick < 65) begin
      send_item(FUNC_MIDI, STATUS_NOTE_ON | {4'h0, chan}, note, vel);
    end else if (pick < 90) begin
      send_item(FUNC_MIDI, STATUS_NOTE_OFF | {4'h0, chan}, note, vel);
    end else begin
      send_item(FUNC_MIDI, 8'($urandom), 7'($urandom), 7'($urandom));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Registers come out of reset at zero offsets; the first tick sees note 0.
  task automatic test_reset_state();
    send_tick();
  endtask

  // Directed note-list cases: field extremes, channel nibble, zero velocity,
  // fall-back to the highest slot, empty list, unknown status, full list.
  task automatic test_note_events();
    send_item(FUNC_MIDI, STATUS_NOTE_ON, 7'd127, 7'd127);
    send_tick();
    // velocity zero is still a note-on; channel 15 is ignored
    send_item(FUNC_MIDI, STATUS_NOTE_ON | 8'h0F, 7'd0, 7'd0);
    send_tick();
    // release the older note first: current falls back to note 0
    send_item(FUNC_MIDI, STATUS_NOTE_OFF | 8'h05, 7'd127, 7'd64);
    send_tick();
    // nothing left: note kept, velocity and gate drop
    send_item(FUNC_MIDI, STATUS_NOTE_OFF | 8'h0F, 7'd0, 7'd127);
    send_tick();
    // unknown status bytes change nothing but the gate evaluation
    send_item(FUNC_MIDI, 8'hB3, 7'd127, 7'd127);
    send_item(FUNC_MIDI, 8'hFF, 7'd127, 7'd127);
    send_item(FUNC_MIDI, 8'h00, 7'd0, 7'd0);
    send_tick();
    // fill every slot with one note, overflow with another, then one
    // note-off clears all copies at once
    for (int i = 0; i < NOTE_SLOTS; i++) begin
      send_item(FUNC_MIDI, STATUS_NOTE_ON | 8'h02, 7'd60, 7'(100 + i));
    end
    send_item(FUNC_MIDI, STATUS_NOTE_ON, 7'd61, 7'd5);
    send_tick();
    send_item(FUNC_MIDI, STATUS_NOTE_OFF, 7'd60, 7'd0);
    send_tick();
  endtask

  // Retrigger: an armed flag survives while disabled and fires on the first
  // tick after enabling; note-ons then arm one low-gate tick, two before a tick give one.
  task automatic test_retrigger();
    settle();
    write_reg(CFG_RETRIGGER, 0);
    send_item(FUNC_MIDI, STATUS_NOTE_ON, 7'd72, 7'd90);
    send_tick();
    settle();
    write_reg(CFG_RETRIGGER, 1);
    send_tick();
    send_tick();
    send_item(FUNC_MIDI, STATUS_NOTE_ON, 7'd74, 7'd30);
    send_item(FUNC_MIDI, STATUS_NOTE_ON, 7'd76, 7'd31);
    send_tick();
    send_tick();
    send_item(FUNC_MIDI, STATUS_NOTE_OFF, 7'd72, 7'd0);
    send_item(FUNC_MIDI, STATUS_NOTE_OFF, 7'd74, 7'd0);
    send_tick();
    send_item(FUNC_MIDI, STATUS_NOTE_OFF, 7'd76, 7'd0);
    send_tick();
  endtask

  // Random traffic under a series of tunings: range limits, values beyond
  // the stated range (full two's complement), and random in-range settings.
  task automatic test_tuning_sweep();
    int oct_v[6]  = '{-5, 5, -8, 7, -5, 0};
    int semi_v[6] = '{-12, 12, -16, 15, 12, 0};
    int cent_v[6] = '{-100, 100, -128, 127, -100, 0};
    int trig_v[6] = '{1, 0, 1, 1, 0, 0};
    logic [6:0] pool_base;
    for (int p = 0; p < 9; p++) begin
      settle();
      if (p < 6) begin
        write_reg(CFG_OCTAVE, oct_v[p]);
        write_reg(CFG_SEMITONE, semi_v[p]);
        write_reg(CFG_CENT, cent_v[p]);
        write_reg(CFG_RETRIGGER, trig_v[p]);
      end else begin
        write_reg(CFG_OCTAVE, $urandom_range(0, 10) - 5);
        write_reg(CFG_SEMITONE, $urandom_range(0, 24) - 12);
        write_reg(CFG_CENT, $urandom_range(0, 200) - 100);
        write_reg(CFG_RETRIGGER, $urandom_range(0, 1));
      end
      pool_base = 7'($urandom_range(0, 122));
      repeat (120) begin
        send_random_item(pool_base);
      end
    end
  endtask

  // Hold the receiver off for a long stretch while items keep coming, so
  // the queue fills and the input stalls.
  task automatic test_backpressure();
    logic [6:0] pool_base;
    pool_base  = 7'($urandom_range(0, 122));
    tx_idle_on = 1'b0;
    rx_hold_req = 1'b1;
    repeat (40) begin
      send_random_item(pool_base);
    end
    tx_idle_on = 1'b1;
  endtask

  // Last stretch at full rate on both sides.
  task automatic test_full_rate();
    logic [6:0] pool_base;
    pool_base  = 7'($urandom_range(0, 122));
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    repeat (150) begin
      send_random_item(pool_base);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_idx_i            = '0;
    cfg_data_i           = '0;
    in_bus.valid         = 1'b0;
    in_bus.func          = FUNC_MIDI;
    in_bus.status_byte   = '0;
    in_bus.note_number   = '0;
    in_bus.note_velocity = '0;
    out_bus.ready        = 1'b0;
    tx_idle_on           = 1'b1;
    rx_idle_on           = 1'b1;
    rx_hold_req          = 1'b0;
    rx_hold_left         = 0;
    rx_stall_left        = 0;
    cv_errors            = 0;
    // predictor starts from the reset state
    for (int i = 0; i < NOTE_SLOTS; i++) begin
      slot_held[i] = 1'b0;
      slot_note[i] = '0;
    end
    cur_note     = '0;
    cur_vel      = '0;
    gate_q       = 1'b0;
    retrig_armed = 1'b0;
    tuning       = '0;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_note_events();
    test_retrigger();
    test_tuning_sweep();
    test_backpressure();
    test_full_rate();

    settle();
    if (cv_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    #(TIMEOUT_NS);
    $display("Mismatches found");
    $finish;
  end

endmodule
